// ----- rtl/rapd_pkg.sv -----
`default_nettype none
package rapd_pkg;
    localparam int BUF_W  = 40;
    localparam int FILL_W = 6;
    localparam int LEN_W  = 5;
    localparam int WIN_W  = 16;
    localparam int CFG_W  = 16;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [13:0] WIDTH_RESET  = 14'd4096;
    localparam logic [15:0] HEIGHT_RESET = 16'd3000;
    localparam logic [2:0]  HEADER_BYTES = 3'd7;
endpackage
`default_nettype wire

// ----- rtl/rapd_bit_window.sv -----
`default_nettype none
// shared bit extractor: the len bits just below the fill mark, MSB first
module rapd_bit_window
    import rapd_pkg::*;
(
    input  wire logic [BUF_W-1:0]  i_buf,
    input  wire logic [FILL_W-1:0] i_fill,
    input  wire logic [LEN_W-1:0]  i_len,
    output logic      [WIN_W-1:0]  o_bits
);
    logic [FILL_W-1:0] w_sh;
    logic [BUF_W-1:0]  w_tmp;
    logic [WIN_W:0]    w_mask;

    always_comb begin
        w_sh   = i_fill - FILL_W'(i_len);
        w_tmp  = i_buf >> w_sh;
        w_mask = ((WIN_W+1)'(1) << i_len) - (WIN_W+1)'(1);
        if (FILL_W'(i_len) > i_fill) begin
            o_bits = '0;
        end else begin
            o_bits = w_tmp[WIN_W-1:0] & w_mask[WIN_W-1:0];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/raw_adaptive_predictive_decoder.sv -----
`default_nettype none
// Lossless adaptive predictive raw decoder.
// Input channel: one compressed stream byte per word (i_valid / o_stall).
//   The first 7 bytes are header and are dropped; the host appends 4 zero
//   bytes so the final pixels decode.
// Output channel: one 16-bit pixel per word (o_valid / i_stall), with
//   o_run_end on the last pixel a byte produced and o_image_end on the
//   final pixel of the image. A byte yields zero, one or two pixels.
// Config: i_cfg_we writes image width (index 0) or height (index 1);
//   write only while idle.
// Sequencing: all decode steps run through one shared bit-window extractor
//   under a small sequencer, one item at a time. A byte that yields no pixel
//   passes only the accept and wrap-check steps; each pixel adds the peek,
//   low, carry and predict steps (plus a high step on the long escape code),
//   bound by the extractor steps and the registered line-store read.
// The output register frees the decoder: a pixel waits there while
//   decoding of the next one proceeds; a stall holds only the final step.
// Reset (synchronous, active low) clears counters, carries, predictors and
//   the bit buffer; the line store needs no clearing (rows are written
//   before they are read back). After the last row further bytes are
//   accepted and dropped until reset.
module raw_adaptive_predictive_decoder
    import rapd_pkg::*;
#(
    parameter int MAX_WIDTH  = 8192,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [7:0]       i_stream_byte,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [15:0]           o_pixel_value,
    output logic                  o_run_end,
    output logic                  o_image_end,
    input  wire logic             i_cfg_we,
    input  wire t_cfg_idx         i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    localparam int PW      = PIXEL_BITS;
    localparam int DEPTH   = 2 * MAX_WIDTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(MAX_WIDTH + 1);
    localparam int LIM     = MAX_WIDTH - (MAX_WIDTH % 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRAP  = 3'd1;
    localparam logic [2:0] S_PEEK  = 3'd2;
    localparam logic [2:0] S_HI    = 3'd3;
    localparam logic [2:0] S_LO    = 3'd4;
    localparam logic [2:0] S_CARRY = 3'd5;
    localparam logic [2:0] S_PRED  = 3'd6;

    logic [2:0]         r_state;
    logic [13:0]        r_width;
    logic [15:0]        r_height;
    logic [2:0]         r_skip;
    logic [BUF_W-1:0]   r_buf;
    logic [FILL_W-1:0]  r_fill;
    logic [15:0]        r_mag  [2];
    logic signed [17:0] r_bias [2];
    logic [1:0]         r_run  [2];
    logic [PW-1:0]      r_left [2];
    logic [PW-1:0]      r_corner [2];
    logic [CW-1:0]      r_col;
    logic [15:0]        r_row;
    logic               r_npix;
    logic [LEN_W-1:0]   r_nbits;
    logic               r_neg;
    logic [1:0]         r_low;
    logic [14:0]        r_hi;
    logic [19:0]        r_a;
    logic [PW-3:0]      r_diff;
    logic [PW-1:0]      r_rd;
    logic [PW-1:0]      r_mem [DEPTH];
    logic               r_ovalid;
    logic [15:0]        r_opix;
    logic               r_orun;
    logic               r_oend;

    // effective width and wrap test
    logic [31:0] w_effw;
    logic        w_col_full;
    logic        w_col_last;
    logic        w_done;
    always_comb begin
        w_effw = 32'({r_width[13:1], 1'b0});
        if (w_effw > 32'(LIM)) w_effw = 32'(LIM);
        if (w_effw < 32'd2) w_effw = 32'd2;
        w_col_full = 32'(r_col) >= w_effw;
        w_col_last = (32'(r_col) + 32'd1) >= w_effw;
        w_done     = r_row >= r_height;
    end

    // shared extractor
    logic [LEN_W-1:0] w_len;
    logic [WIN_W-1:0] w_win;
    always_comb begin
        unique case (r_state)
            S_PEEK:  w_len = LEN_W'(15);
            S_HI:    w_len = LEN_W'(16) - r_nbits;
            default: w_len = r_nbits;
        endcase
    end

    rapd_bit_window u_win (
        .i_buf  (r_buf),
        .i_fill (r_fill),
        .i_len  (w_len),
        .o_bits (w_win)
    );

    // field split and suffix length
    logic             w_p;
    logic [3:0]       w_zeros;
    logic [4:0]       w_blen;
    logic [LEN_W-1:0] w_ext;
    logic [LEN_W-1:0] w_nbits;
    always_comb begin
        w_p     = r_col[0];
        w_zeros = 4'd12;
        for (int k = 0; k < 12; k++) begin
            if (w_win[k]) w_zeros = 4'(11 - k);
        end
        w_blen = '0;
        for (int k = 0; k < 16; k++) begin
            if (r_mag[w_p][k]) w_blen = 5'(k + 1);
        end
        w_ext   = (r_run[w_p] < 2'd3) ? LEN_W'(2) : LEN_W'(0);
        w_nbits = LEN_W'(2) + w_ext;
        if (w_blen > w_nbits + w_ext) w_nbits = w_blen - w_ext;
    end

    // carry update
    logic signed [20:0] w_sa;
    logic signed [21:0] w_dif;
    logic signed [23:0] w_t;
    always_comb begin
        w_sa  = r_neg ? ~signed'({1'b0, r_a}) : signed'({1'b0, r_a});
        w_dif = 22'(w_sa) + 22'(r_bias[w_p]);
        w_t   = 24'(w_dif) * 24'sd3 + 24'(r_bias[w_p]);
    end

    // predictor
    logic [PW-1:0]      w_up;
    logic signed [PW:0] w_lmn;
    logic signed [PW:0] w_umn;
    logic [PW:0]        w_alm;
    logic [PW:0]        w_aum;
    logic [PW:0]        w_sum;
    logic [PW-1:0]      w_pred;
    logic [PW-1:0]      w_val;
    logic               w_edge;
    logic               w_newrow;
    logic [15:0]        w_row_nx;
    logic               w_done_nx;
    logic               w_more;
    logic               w_out_free;
    always_comb begin
        w_up   = (r_row >= 16'd2) ? r_rd : '0;
        w_lmn  = signed'({1'b0, r_left[w_p]}) - signed'({1'b0, r_corner[w_p]});
        w_umn  = signed'({1'b0, w_up}) - signed'({1'b0, r_corner[w_p]});
        w_alm  = w_lmn[PW] ? (PW+1)'(-w_lmn) : (PW+1)'(w_lmn);
        w_aum  = w_umn[PW] ? (PW+1)'(-w_umn) : (PW+1)'(w_umn);
        w_sum  = (PW+1)'(r_left[w_p]) + (PW+1)'(w_up);
        w_edge = (r_row < 16'd2) || (32'(r_col) < 32'd2);
        if (w_edge) begin
            if (r_row < 16'd2 && 32'(r_col) < 32'd2) w_pred = '0;
            else if (r_row < 16'd2)                  w_pred = r_left[w_p];
            else                                      w_pred = w_up;
        end else if ((w_lmn < 0 && w_umn > 0) || (w_lmn > 0 && w_umn < 0)) begin
            if (w_alm > (PW+1)'(32) || w_aum > (PW+1)'(32))
                w_pred = r_left[w_p] + w_umn[PW-1:0];
            else
                w_pred = w_sum[PW:1];
        end else begin
            w_pred = (w_alm > w_aum) ? r_left[w_p] : w_up;
        end
        w_val      = w_pred + {r_diff, r_low};
        w_newrow   = w_col_last;
        w_row_nx   = w_newrow ? r_row + 16'd1 : r_row;
        w_done_nx  = w_row_nx >= r_height;
        w_more     = !r_npix && !w_done_nx && (r_fill >= FILL_W'(32));
        w_out_free = !r_ovalid || !i_stall;
    end

    logic [AW-1:0] w_slot;
    always_comb begin
        if (r_row[0]) w_slot = AW'(MAX_WIDTH) + AW'(r_col);
        else          w_slot = AW'(r_col);
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (r_state == S_LO) r_rd <= r_mem[w_slot];
        if (r_state == S_PRED && w_out_free) r_mem[w_slot] <= w_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_skip   <= HEADER_BYTES;
            r_buf    <= '0;
            r_fill   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_npix   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_mag[i]    <= '0;
                r_bias[i]   <= '0;
                r_run[i]    <= '0;
                r_left[i]   <= '0;
                r_corner[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IMAGE_WIDTH) r_width  <= i_cfg_data[13:0];
                else                              r_height <= i_cfg_data;
            end
            // in S_PRED the output register is reloaded instead
            if (r_ovalid && !i_stall && r_state != S_PRED) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (r_skip != 3'd0) begin
                            r_skip <= r_skip - 3'd1;
                        end else if (!w_done) begin
                            r_buf   <= {r_buf[BUF_W-9:0], i_stream_byte};
                            r_fill  <= r_fill + FILL_W'(8);
                            r_npix  <= 1'b0;
                            r_state <= S_WRAP;
                        end
                    end
                end
                S_WRAP: begin
                    if (r_fill < FILL_W'(32)) begin
                        r_state <= S_IDLE;
                    end else begin
                        if (w_col_full) begin
                            r_col <= '0;
                            r_row <= r_row + 16'd1;
                            for (int i = 0; i < 2; i++) begin
                                r_mag[i]  <= '0;
                                r_bias[i] <= '0;
                                r_run[i]  <= '0;
                            end
                        end
                        r_state <= S_PEEK;
                    end
                end
                S_PEEK: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_nbits <= w_nbits;
                        r_neg   <= w_win[14];
                        r_low   <= w_win[13:12];
                        if (w_zeros == 4'd12) begin
                            r_fill  <= r_fill - FILL_W'(15);
                            r_state <= S_HI;
                        end else begin
                            r_fill  <= r_fill - FILL_W'(w_zeros) - FILL_W'(4);
                            r_hi    <= 15'(w_zeros);
                            r_state <= S_LO;
                        end
                    end
                end
                S_HI: begin
                    r_fill  <= r_fill - FILL_W'(w_len);
                    r_hi    <= w_win[15:1];
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_fill  <= r_fill - FILL_W'(w_len);
                    r_a     <= (20'(r_hi) << r_nbits) | 20'(w_win);
                    r_state <= S_CARRY;
                end
                S_CARRY: begin
                    r_bias[w_p] <= 18'(w_t >>> 5);
                    r_mag[w_p]  <= r_a[15:0];
                    if (r_a > 20'd16)           r_run[w_p] <= 2'd0;
                    else if (r_run[w_p] != 2'd3) r_run[w_p] <= r_run[w_p] + 2'd1;
                    r_diff  <= w_dif[PW-3:0];
                    r_state <= S_PRED;
                end
                S_PRED: begin
                    if (w_out_free) begin
                        r_left[w_p] <= w_val;
                        if (r_row >= 16'd2) r_corner[w_p] <= w_up;
                        r_ovalid <= 1'b1;
                        r_opix   <= 16'(w_val);
                        r_orun   <= !w_more;
                        r_oend   <= w_done_nx;
                        r_npix   <= 1'b1;
                        if (w_newrow) begin
                            r_col <= '0;
                            r_row <= w_row_nx;
                            for (int i = 0; i < 2; i++) begin
                                r_mag[i]  <= '0;
                                r_bias[i] <= '0;
                                r_run[i]  <= '0;
                            end
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                        r_state <= w_more ? S_PEEK : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_pixel_value = r_opix;
    assign o_run_end     = r_orun;
    assign o_image_end   = r_oend;
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import rapd_pkg::*;

    localparam int MAXW       = 8192;
    localparam int DRAIN_WAIT = 20;       // > slowest no-pixel byte plus in-flight pixel
    localparam int CYCLE_CAP  = 2000000;

    typedef struct packed {
        logic [15:0] pix;
        logic        run_end;
        logic        img_end;
    } pix_word_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_stream_byte;
    logic             o_valid;
    logic             i_stall;
    logic [15:0]      o_pixel_value;
    logic             o_run_end;
    logic             o_image_end;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    raw_adaptive_predictive_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_stream_byte (i_stream_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_value (o_pixel_value),
        .o_run_end     (o_run_end),
        .o_image_end   (o_image_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // Decoder shadow state
    // ---------------------------------------------------------------
    logic [39:0]  bitbuf;
    int unsigned  fill;
    int unsigned  hdr_left;
    int unsigned  cmag [2];
    int           cbias [2];
    int unsigned  crun [2];
    int unsigned  leftp [2];
    int unsigned  cornp [2];
    logic [15:0]  rows_mem [0:2*MAXW-1];
    int unsigned  col_cnt;
    int unsigned  row_cnt;
    int unsigned  width_reg;
    int unsigned  height_reg;

    pix_word_t    expected_pixels [$];

    int           n_errors;
    int           n_bytes;
    int           n_pixels;
    int           n_images;
    int           n_cycles;
    bit           no_gaps;
    bit           long_hold;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_reg & ~32'd1;
        if (w > MAXW) w = MAXW;
        if (w < 2) w = 2;
        return w;
    endfunction

    function automatic void new_row();
        col_cnt = 0;
        row_cnt++;
        for (int k = 0; k < 2; k++) begin
            cmag[k]  = 0;
            cbias[k] = 0;
            crun[k]  = 0;
        end
    endfunction

    function automatic int unsigned take_bits(int unsigned n);
        logic [63:0] v;
        if (n == 0 || n > fill) return 0;
        v = (64'(bitbuf) >> (fill - n)) & ((64'd1 << n) - 64'd1);
        fill -= n;
        return int'(v[31:0]);
    endfunction

    function automatic int unsigned iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Decode one pixel at the current column; updates carries and predictors.
    function automatic logic [15:0] decode_pixel();
        int unsigned p, col, mag, ext, nbits, zeros, hi, a, slot, up, pred;
        logic [14:0] b;
        logic        neg;
        logic [1:0]  low;
        longint      sa, diff, t, fdiv;
        logic [31:0] resid;
        int          lmn, umn;
        p     = col_cnt & 1;
        col   = col_cnt;
        mag   = cmag[p];
        ext   = (crun[p] < 3) ? 2 : 0;
        nbits = 2 + ext;
        up    = 0;
        while ((mag >> (nbits + ext)) != 0) nbits++;

        b     = 15'(bitbuf >> (fill - 15));
        neg   = b[14];
        low   = b[13:12];
        zeros = 0;
        while (zeros < 12 && !b[11 - zeros]) zeros++;

        if (zeros == 12) begin
            // escape: long form, high part from 16-nbits bits
            fill -= 15;
            hi = take_bits(16 - nbits) >> 1;
        end else begin
            fill -= zeros + 4;
            hi = zeros;
        end
        a = (hi << nbits) | take_bits(nbits);

        sa   = neg ? -longint'(a) - 1 : longint'(a);
        diff = sa + cbias[p];
        t    = diff * 3 + cbias[p];
        fdiv = (t >= 0) ? (t >>> 5) : -(((-t) + 31) / 32);
        cbias[p] = int'(fdiv);
        cmag[p]  = a & 32'hFFFF;
        crun[p]  = (a > 16) ? 0 : ((crun[p] < 3) ? crun[p] + 1 : 3);
        resid    = {diff[29:0], low};

        slot = (row_cnt & 1) * MAXW + col;
        if (slot >= 2 * MAXW) slot = 0;
        if (row_cnt >= 2) up = rows_mem[slot];

        if (row_cnt < 2 || col < 2) begin
            if (row_cnt < 2 && col < 2) begin
                pred = 0;
            end else if (row_cnt < 2) begin
                pred = leftp[p];
            end else begin
                pred     = up;
                cornp[p] = up;
            end
        end else begin
            lmn = int'(leftp[p]) - int'(cornp[p]);
            umn = int'(up) - int'(cornp[p]);
            if ((lmn < 0 && umn > 0) || (lmn > 0 && umn < 0)) begin
                // gradients disagree: edge-directed or average
                if (iabs(lmn) > 32 || iabs(umn) > 32)
                    pred = int'(leftp[p]) + umn;
                else
                    pred = (leftp[p] + up) >> 1;
            end else begin
                pred = (iabs(lmn) > iabs(umn)) ? leftp[p] : up;
            end
            cornp[p] = up;
        end

        decode_pixel   = 16'(pred + resid);
        rows_mem[slot] = decode_pixel;
        leftp[p]       = decode_pixel;
    endfunction

    // Predict the pixels one accepted stream byte produces.
    function automatic void predict_byte(logic [7:0] sb);
        pix_word_t got [$];
        pix_word_t w;
        if (hdr_left > 0) begin
            hdr_left--;
            return;
        end
        if (row_cnt >= height_reg) return;
        bitbuf = {bitbuf[31:0], sb};
        fill += 8;
        while (got.size() < 2 && fill >= 32) begin
            if (col_cnt >= eff_width()) new_row();
            if (row_cnt >= height_reg) break;
            w.pix     = decode_pixel();
            w.run_end = 1'b0;
            w.img_end = 1'b0;
            col_cnt++;
            if (col_cnt >= eff_width()) new_row();
            if (row_cnt >= height_reg) begin
                w.img_end = 1'b1;
                got.push_back(w);
                break;
            end
            got.push_back(w);
        end
        if (got.size() > 0) got[got.size() - 1].run_end = 1'b1;
        foreach (got[k]) expected_pixels.push_back(got[k]);
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    function automatic logic [7:0] stream_byte_rand();
        case ($urandom_range(0, 9))
            0, 1:    return 8'h00;   // zero runs hit the escape code
            2:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one byte; returns on the edge it is taken.
    task automatic send_byte(input logic [7:0] sb);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_stream_byte <= sb;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        n_bytes++;
        predict_byte(sb);
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            send_byte(stream_byte_rand());
        end
        no_gaps = 1'b0;
    endtask

    // Wait until every pending pixel is out, plus settle time.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_IMAGE_WIDTH) width_reg = val & 32'h3FFF;
        else height_reg = val & 32'hFFFF;
    endtask

    // ---------------------------------------------------------------
    // Pixel receiver and checker
    // ---------------------------------------------------------------
    initial begin
        pix_word_t exp_w;
        logic [15:0] pv;
        logic re, ie;
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 11);
            if (gap > 0 || long_hold) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                while (long_hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(negedge i_clk);
            while (!o_valid) begin
                @(posedge i_clk);
                @(negedge i_clk);
            end
            pv = o_pixel_value;
            re = o_run_end;
            ie = o_image_end;
            @(posedge i_clk);
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel word: value %0h", pv);
                n_errors++;
            end else begin
                exp_w = expected_pixels.pop_front();
                n_pixels++;
                if (ie) n_images++;
                if (pv !== exp_w.pix) begin
                    $error("pixel_value: expected %0h, got %0h", exp_w.pix, pv);
                    n_errors++;
                end
                if (re !== exp_w.run_end) begin
                    $error("run_end: expected %0b, got %0b", exp_w.run_end, re);
                    n_errors++;
                end
                if (ie !== exp_w.img_end) begin
                    $error("image_end: expected %0b, got %0b", exp_w.img_end, ie);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Header drop, field extremes and escape codes on one very wide row
    // (width above range clamps to the maximum). Only rows 0/1 here, so
    // nothing reads the line store yet.
    task automatic test_header_wide_row();
        logic [7:0] pat [$];
        write_reg(CFG_IMAGE_WIDTH, 16383);
        write_reg(CFG_IMAGE_HEIGHT, 65535);
        pat = '{8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F,   // header
                8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h7F,
                8'h55, 8'hAA, 8'h01, 8'hFE, 8'h00, 8'h00, 8'h10, 8'hC3};
        foreach (pat[k]) send_byte(pat[k]);
        send_random(60);
        drain();
    endtask

    // Width lowered mid-row ends that row; widths only shrink from here so
    // every line store read hits a slot written two rows earlier.
    task automatic test_rows(input int unsigned w, input int count);
        write_reg(CFG_IMAGE_WIDTH, w);
        send_random(count);
        drain();
    endtask

    // Receiver holds off long while bytes keep coming, backing up the input.
    task automatic test_backpressure();
        fork
            begin
                long_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
        join_none
        send_random(150);
        drain();
    endtask

    // Height set to end the image two rows after the current one: image ends, then bytes drop.
    task automatic test_image_end();
        int guard;
        write_reg(CFG_IMAGE_HEIGHT, row_cnt + 3);
        guard = 0;
        while (row_cnt < height_reg && guard < 4000) begin
            send_byte(stream_byte_rand());
            guard++;
        end
        send_random(20);
        drain();
        write_reg(CFG_IMAGE_HEIGHT, 0);
        send_random(10);
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_stream_byte = 8'h00;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_IMAGE_WIDTH;
        i_cfg_data    = '0;
        n_errors = 0;
        n_bytes  = 0;
        n_pixels = 0;
        n_images = 0;
        n_cycles = 0;
        no_gaps   = 1'b0;
        long_hold = 1'b0;
        bitbuf   = '0;
        fill     = 0;
        hdr_left = 7;
        for (int k = 0; k < 2; k++) begin
            cmag[k]  = 0;
            cbias[k] = 0;
            crun[k]  = 0;
            leftp[k] = 0;
            cornp[k] = 0;
        end
        col_cnt    = 0;
        row_cnt    = 0;
        width_reg  = 4096;
        height_reg = 3000;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_wide_row();
        test_rows(64, 500);
        test_rows(33, 350);      // odd: low bit ignored
        test_backpressure();
        test_rows(10, 300);
        test_rows(2, 250);       // narrowest row
        test_rows(0, 150);       // clamps up to 2
        test_image_end();

        $display("Decoded %0d stream bytes into %0d pixels, %0d image end(s).",
                 n_bytes, n_pixels, n_images);
        $display("Widths from clamped max down to 2, escapes, long stall, post-image drop.");
        if (n_errors == 0 && expected_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/rapd_pkg.sv
rtl/rapd_bit_window.sv
rtl/raw_adaptive_predictive_decoder.sv
sim/tb_top.sv
